// ===== src/dbtf_pkg.sv =====
// ----------------------------------------------------------------------------
// dbtf_pkg: shared types and constants of the block trigger filter
// Phase codes, word structs and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package dbtf_pkg;

  localparam int unsigned MaskBits = 32;
  localparam logic [31:0] BankMask = 32'hFF20_2000;

  // parse phase of the current block
  typedef enum logic [3:0] {
    PH_LEN, PH_HEAD, PH_BANKLEN, PH_BANKHDR, PH_H64, PH_SEG64, PH_H16,
    PH_SEG16, PH_CRATEHDR, PH_CRATEX, PH_CRATE1, PH_SKIP
  } phase_e;

  // controller state
  typedef enum logic [1:0] {
    ST_IDLE, ST_WORK, ST_DIV, ST_OUT
  } ctrl_e;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0, KIND_SLOW = 3'd1, KIND_BOR = 3'd2,
    KIND_CONTROL = 3'd3, KIND_BUILT = 3'd4, KIND_PHYS = 3'd5
  } kind_e;

  typedef struct packed {
    logic [31:0] data_word;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic        keep_block;
    logic [2:0]  event_kind;
    logic [7:0]  event_count;
    logic [31:0] fp_or_mask;
    logic [31:0] gtp_or_mask;
    logic        bank_error;
    logic [63:0] first_evnum;
    logic [63:0] last_evnum;
    logic [31:0] run_num;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input word
    logic step;      // run one parse step on the held word
    logic div_start; // begin stride division
    logic div_step;  // one bit of stride division
    logic finish;    // build the result and clear the block
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;  // held word is a crate 1 header needing a stride
    logic div_done;
    logic last;      // held word ends the block
  } dp_stat_t;

  function automatic kind_e classify(input logic [15:0] tag);
    kind_e k;
    k = KIND_UNKNOWN;
    if (tag == 16'h0060) k = KIND_SLOW;
    else if (tag == 16'h0070) k = KIND_BOR;
    else if (tag >= 16'hFFD0 && tag <= 16'hFFD4) k = KIND_CONTROL;
    else if (tag == 16'hFF58 || tag == 16'hFF78 || tag == 16'hFF50 || tag == 16'hFF70)
      k = KIND_BUILT;
    else if (tag == 16'hFF32 || tag == 16'hFF33) k = KIND_PHYS;
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== src/dbtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dbtf_ctrl: sequencing of word intake, stride division and result hand-off
// One word is held at a time; crate 1 headers run a 16-step divider.
// ----------------------------------------------------------------------------
`default_nettype none
module dbtf_ctrl import dbtf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  ctrl_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_WORK;
      ST_WORK: begin
        if (stat_i.need_div)  state_d = ST_DIV;
        else if (stat_i.last) state_d = ST_OUT;
        else                  state_d = ST_IDLE;
      end
      ST_DIV: if (stat_i.div_done) state_d = stat_i.last ? ST_OUT : ST_IDLE;
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_WORK: begin
        cmd_o.step      = !stat_i.need_div;
        cmd_o.div_start = stat_i.need_div;
        cmd_o.finish    = !stat_i.need_div && stat_i.last;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.step     = stat_i.div_done;
        cmd_o.finish   = stat_i.div_done && stat_i.last;
      end
      ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/dbtf_dp.sv =====
// ----------------------------------------------------------------------------
// dbtf_dp: parse state, mask accumulation, event numbers and stride divider
// Runs one parse step per command on the held word.
// ----------------------------------------------------------------------------
`default_nettype none
module dbtf_dp import dbtf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire in_word_t    in_word_i,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  output out_word_t        out_word_o
);

  logic [31:0] word_q;
  logic        last_q;
  logic [31:0] ignore_q;
  phase_e      phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  events_q, events_d;
  logic [15:0] tag_q, tag_d;
  logic [7:0]  crates_q, crates_d;
  logic [15:0] stride_q, stride_d;
  logic [15:0] pos_q, pos_d;
  logic [31:0] fp_q, fp_d, gtp_q, gtp_d, low_q, low_d, run_q, run_d;
  logic [63:0] first_q, first_d, last_ev_q, last_ev_d;
  kind_e       kind_q, kind_d;
  logic        err_q, err_d;
  logic [7:0]  cev_q, cev_d;
  out_word_t   out_q;

  // divider
  logic [15:0] quo_q, rem_q;
  logic [4:0]  dcnt_q;
  logic [16:0] rem_sh;

  logic [15:0] len;
  logic [63:0] first_num, last_num;
  logic        is_c1;

  assign len       = word_q[15:0];
  assign is_c1     = (word_q[31:24] == 8'd1) &&
                     ({1'b0, len} >= {8'd0, events_q, 1'b0});
  assign first_num = {word_q, low_q};
  assign last_num  = first_num + {56'd0, events_q} - 64'd1;
  assign rem_sh    = {rem_q, quo_q[15]};

  assign stat_o.need_div = (phase_q == PH_CRATEHDR) && is_c1;
  assign stat_o.div_done = (dcnt_q == 5'd15);
  assign stat_o.last     = last_q;
  assign out_word_o      = out_q;

  // input word capture and configuration
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      word_q <= in_word_i.data_word;
      last_q <= in_word_i.last_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       ignore_q <= '0;
    else if (cfg_we_i) ignore_q <= cfg_wdata_i;
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q <= '0; rem_q <= '0; dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      quo_q <= len; rem_q <= '0; dcnt_q <= '0;
    end else if (cmd_i.div_step && dcnt_q != 5'd16) begin
      dcnt_q <= dcnt_q + 5'd1;
      if (rem_sh >= {9'd0, events_q}) begin
        rem_q <= 16'(rem_sh - {9'd0, events_q});
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= rem_sh[15:0];
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
  end

  // quotient as it stands after the final divider step
  logic [15:0] quo_fin;
  always_comb begin
    quo_fin = {quo_q[14:0], (rem_sh >= {9'd0, events_q})};
  end

  // parse step
  always_comb begin
    phase_d = phase_q; count_d = count_q; events_d = events_q; tag_d = tag_q;
    crates_d = crates_q; stride_d = stride_q; pos_d = pos_q; fp_d = fp_q;
    gtp_d = gtp_q; low_d = low_q; run_d = run_q; first_d = first_q;
    last_ev_d = last_ev_q; kind_d = kind_q; err_d = err_q; cev_d = cev_q;
    unique case (phase_q)
      PH_LEN: phase_d = PH_HEAD;
      PH_HEAD: begin
        kind_d   = classify(word_q[31:16]);
        events_d = (kind_d == KIND_BUILT) ? word_q[7:0] : 8'd1;
        phase_d  = (kind_d == KIND_BUILT && events_d != 8'd0) ? PH_BANKLEN : PH_SKIP;
      end
      PH_BANKLEN: phase_d = PH_BANKHDR;
      PH_BANKHDR: begin
        if ((word_q & BankMask) != BankMask) begin
          err_d = 1'b1; phase_d = PH_SKIP;
        end else begin
          tag_d = word_q[31:16]; crates_d = word_q[7:0]; phase_d = PH_H64;
        end
      end
      PH_H64: begin
        count_d = len; pos_d = '0;
        phase_d = (len == 16'd0) ? PH_H16 : PH_SEG64;
      end
      PH_SEG64: begin
        if (pos_q == 16'd0) low_d = word_q;
        else if (pos_q == 16'd1) begin
          if (first_q == 64'd0) first_d = first_num;
          if (last_ev_q < last_num) last_ev_d = last_num;
        end
        if (tag_q[1] && {1'b0, pos_q} == ({9'd0, events_q} << 1) + 17'd3) run_d = word_q;
        pos_d = pos_q + 16'd1; count_d = count_q - 16'd1;
        if (count_d == 16'd0) phase_d = PH_H16;
      end
      PH_H16: begin
        count_d = len;
        if (len == 16'd0) phase_d = (crates_q == 8'd0) ? PH_SKIP : PH_CRATEHDR;
        else phase_d = PH_SEG16;
      end
      PH_SEG16, PH_CRATEX: begin
        count_d = count_q - 16'd1;
        if (count_d == 16'd0) phase_d = (crates_q == 8'd0) ? PH_SKIP : PH_CRATEHDR;
      end
      PH_CRATEHDR: begin
        crates_d = crates_q - 8'd1; count_d = len;
        if (word_q[31:24] == 8'd1) begin
          if (!is_c1) begin
            err_d = 1'b1; phase_d = PH_SKIP;
          end else begin
            stride_d = quo_fin; pos_d = '0; cev_d = events_q;
            if (len == 16'd0) phase_d = (crates_d == 8'd0) ? PH_SKIP : PH_CRATEHDR;
            else phase_d = PH_CRATE1;
          end
        end else begin
          if (len == 16'd0) phase_d = (crates_d == 8'd0) ? PH_SKIP : PH_CRATEHDR;
          else phase_d = PH_CRATEX;
        end
      end
      PH_CRATE1: begin
        if (cev_q != 8'd0) begin
          if (stride_q > 16'd3) begin
            if (pos_q == 16'd2) gtp_d = gtp_q | word_q;
            else if (pos_q == 16'd3) fp_d = fp_q | word_q;
          end
          pos_d = pos_q + 16'd1;
          if (pos_d >= stride_q) begin
            pos_d = '0; cev_d = cev_q - 8'd1;
          end
        end
        count_d = count_q - 16'd1;
        if (count_d == 16'd0) phase_d = (crates_q == 8'd0) ? PH_SKIP : PH_CRATEHDR;
      end
      default: ;
    endcase
  end

  // parse registers; block state other than run and event numbers clears when the result is built
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN; count_q <= '0; events_q <= '0; tag_q <= '0;
      crates_q <= '0; stride_q <= '0; pos_q <= '0; fp_q <= '0; gtp_q <= '0;
      low_q <= '0; run_q <= '0; first_q <= '0; last_ev_q <= '0;
      kind_q <= KIND_UNKNOWN; err_q <= 1'b0; cev_q <= '0;
    end else if (cmd_i.step) begin
      run_q <= run_d; first_q <= first_d; last_ev_q <= last_ev_d;
      if (cmd_i.finish) begin
        phase_q <= PH_LEN; count_q <= '0; events_q <= '0; tag_q <= '0;
        crates_q <= '0; stride_q <= '0; pos_q <= '0; fp_q <= '0; gtp_q <= '0;
        low_q <= '0; kind_q <= KIND_UNKNOWN; err_q <= 1'b0; cev_q <= '0;
      end else begin
        phase_q <= phase_d; count_q <= count_d; events_q <= events_d;
        tag_q <= tag_d; crates_q <= crates_d; stride_q <= stride_d;
        pos_q <= pos_d; fp_q <= fp_d; gtp_q <= gtp_d; low_q <= low_d;
        kind_q <= kind_d; err_q <= err_d; cev_q <= cev_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.keep_block  <= (kind_d == KIND_BUILT) ?
                           ((fp_d & ~ignore_q & MaskBits'('1)) != '0) : 1'b1;
      out_q.event_kind  <= kind_d;
      out_q.event_count <= (kind_d == KIND_BUILT) ? events_d : 8'd1;
      out_q.fp_or_mask  <= fp_d;
      out_q.gtp_or_mask <= gtp_d;
      out_q.bank_error  <= err_d;
      out_q.first_evnum <= first_d;
      out_q.last_evnum  <= last_ev_d;
      out_q.run_num     <= run_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/daq_block_trigger_filter.sv =====
// ----------------------------------------------------------------------------
// daq_block_trigger_filter: keep/drop decision for data-acquisition blocks
// Parses each block word by word and emits one decision on its last word.
// ----------------------------------------------------------------------------
// Each word is accepted, then given one parse step; a crate 1 section header
// also runs the bit-serial stride divider before its parse step. The word
// ending a block yields one result word, held until taken; the next word is
// accepted once the result has left. fp_ignore_mask is written through cfg_we_i.
`default_nettype none
module daq_block_trigger_filter import dbtf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_word_t    in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_word_t        out_word_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dbtf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  dbtf_dp u_dp (
    .clk_i, .rst_ni, .in_word_i, .cfg_we_i, .cfg_wdata_i,
    .cmd_i(cmd), .stat_o(stat), .out_word_o
  );

  // no word taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("input accepted while result pending");

  // result appears only after a finishing step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.finish))
    else $error("result without finish");

  // blocks other than built physics are always kept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.event_kind != KIND_BUILT |-> out_word_o.keep_block)
    else $error("non-physics block dropped");

endmodule
`default_nettype wire
